// File: design/pwom_pkg.sv
// types, constants and microcode program of the point window outlier mean block
package pwom_pkg;

  localparam int COORD_W = 16;
  localparam int HELD_W  = 4;
  localparam int STEP_W  = 4;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [HELD_W-1:0]         held_t;
  typedef logic [STEP_W-1:0]         step_t;

  typedef enum logic [3:0] {
    OP_ACCEPT,
    OP_FETCH,
    OP_SUM,
    OP_DIFF,
    OP_SQUARE,
    OP_COMPARE,
    OP_DIV_LOAD,
    OP_DIV_STEP,
    OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    C_NONE,
    C_ALWAYS,
    C_MORE,
    C_DIV_BUSY
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    step_t target;
  } ctrl_word_t;

  localparam step_t STEP_WAIT     = 4'd0;
  localparam step_t STEP_FETCH_S  = 4'd1;
  localparam step_t STEP_SUM      = 4'd2;
  localparam step_t STEP_FETCH_D  = 4'd3;
  localparam step_t STEP_DIFF     = 4'd4;
  localparam step_t STEP_SQUARE   = 4'd5;
  localparam step_t STEP_COMPARE  = 4'd6;
  localparam step_t STEP_DIV_LOAD = 4'd7;
  localparam step_t STEP_DIV      = 4'd8;
  localparam step_t STEP_EMIT     = 4'd9;

  // control store: one word per step, jump to target when the condition holds
  function automatic ctrl_word_t program_word(input step_t step);
    ctrl_word_t w;
    case (step)
      STEP_WAIT:     w = '{OP_ACCEPT,   C_NONE,     STEP_WAIT};
      STEP_FETCH_S:  w = '{OP_FETCH,    C_NONE,     STEP_WAIT};
      STEP_SUM:      w = '{OP_SUM,      C_MORE,     STEP_FETCH_S};
      STEP_FETCH_D:  w = '{OP_FETCH,    C_NONE,     STEP_WAIT};
      STEP_DIFF:     w = '{OP_DIFF,     C_NONE,     STEP_WAIT};
      STEP_SQUARE:   w = '{OP_SQUARE,   C_NONE,     STEP_WAIT};
      STEP_COMPARE:  w = '{OP_COMPARE,  C_MORE,     STEP_FETCH_D};
      STEP_DIV_LOAD: w = '{OP_DIV_LOAD, C_NONE,     STEP_WAIT};
      STEP_DIV:      w = '{OP_DIV_STEP, C_DIV_BUSY, STEP_DIV};
      STEP_EMIT:     w = '{OP_EMIT,     C_ALWAYS,   STEP_WAIT};
      default:       w = '{OP_FETCH,    C_ALWAYS,   STEP_WAIT};
    endcase
    return w;
  endfunction

endpackage

// File: design/pwom_point_if.sv
// request channel carrying one input point
interface pwom_point_if import pwom_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t point_x;
  coord_t point_y;

  modport source (output valid, output point_x, output point_y, input ready);
  modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

// File: design/pwom_est_if.sv
// request channel carrying one stabilized estimate
interface pwom_est_if import pwom_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t est_x;
  coord_t est_y;
  held_t  points_held;

  modport source (output valid, output est_x, output est_y, output points_held, input ready);
  modport sink   (input valid, input est_x, input est_y, input points_held, output ready);
endinterface

// File: design/point_window_outlier_mean.sv
// top level: microcoded sliding window mean with farthest point rejection
//
//  channel    dir  payload                          handshake
//  points     in   point_x, point_y (s16 each)      valid/ready
//  estimates  out  est_x, est_y (s16), points_held  valid/ready
//
// the time one request takes grows with n, the number of points held, and is
// set by the single-port ring read per step, the per-point distance steps and
// the bit-serial divider.
// points.ready is high only in the wait step; an estimate waits in the output
// register and the next point is taken meanwhile. synchronous reset empties the
// window; ring contents need no clearing.
module point_window_outlier_mean import pwom_pkg::*; #(
  parameter int WINDOW = 8
) (
  input logic         clk,
  input logic         rst,
  pwom_point_if.sink  points,
  pwom_est_if.source  estimates
);

  localparam int IW = $clog2(WINDOW);
  localparam int CW = $clog2(WINDOW + 1);
  localparam int SW = COORD_W + CW;
  localparam int NW = SW + 1;
  localparam int DW = COORD_W + 1 + CW;
  localparam int QW = 2 * DW;
  localparam int KW = $clog2(NW + 1);

  // window storage
  logic [2*COORD_W-1:0] ring [WINDOW];
  logic [2*COORD_W-1:0] rd_data;
  logic [IW-1:0]        write_slot;
  logic [CW-1:0]        filled_count;
  logic [CW-1:0]        filled_next;

  // datapath registers
  logic [IW-1:0]          idx;
  logic signed [SW-1:0]   sx, sy;
  logic signed [DW-1:0]   dx, dy;
  logic [QW-1:0]          sqx, sqy;
  logic [QW:0]            best;
  logic                   bad_ok;
  coord_t                 bx, by;
  logic [NW-1:0]          quo_x, quo_y;
  logic [CW-1:0]          rem_x, rem_y;
  logic [CW-1:0]          den;
  logic                   neg_x, neg_y;
  logic [KW-1:0]          div_cnt;

  // sequencer
  step_t      step, step_next;
  ctrl_word_t cw;
  logic       hold;
  logic       more;
  logic       jump;
  logic       accept;

  // combinational datapath values
  coord_t               px, py;
  logic signed [DW-1:0] nx, ny;
  logic [QW:0]          dist_sq;
  logic signed [NW-1:0] num_x, num_y;
  logic [NW-1:0]        mag_x, mag_y;
  logic [CW:0]          rsh_x, rsh_y;
  logic [NW-1:0]        res_x, res_y;

  assign cw     = program_word(step);
  assign px     = $signed(rd_data[COORD_W-1:0]);
  assign py     = $signed(rd_data[2*COORD_W-1:COORD_W]);
  assign accept = points.valid && points.ready;
  assign points.ready = (cw.op == OP_ACCEPT);
  assign more   = (CW'(idx) + 1'b1) != filled_count;
  assign filled_next = (filled_count == CW'(WINDOW)) ? filled_count : filled_count + 1'b1;

  assign nx      = $signed({1'b0, filled_count}) * px;
  assign ny      = $signed({1'b0, filled_count}) * py;
  assign dist_sq = {1'b0, sqx} + {1'b0, sqy};

  // numerator leaves out the farthest point when one was found
  assign num_x = bad_ok ? ({sx[SW-1], sx} - {{(NW-COORD_W){bx[COORD_W-1]}}, bx})
                        : {sx[SW-1], sx};
  assign num_y = bad_ok ? ({sy[SW-1], sy} - {{(NW-COORD_W){by[COORD_W-1]}}, by})
                        : {sy[SW-1], sy};
  assign mag_x = num_x[NW-1] ? (~num_x + 1'b1) : num_x;
  assign mag_y = num_y[NW-1] ? (~num_y + 1'b1) : num_y;

  assign rsh_x = {rem_x, quo_x[NW-1]};
  assign rsh_y = {rem_y, quo_y[NW-1]};
  assign res_x = neg_x ? (~quo_x + 1'b1) : quo_x;
  assign res_y = neg_y ? (~quo_y + 1'b1) : quo_y;

  always_comb begin
    hold = 1'b0;
    case (cw.op)
      OP_ACCEPT: hold = !points.valid;
      OP_EMIT:   hold = estimates.valid && !estimates.ready;
      default:   hold = 1'b0;
    endcase
    case (cw.cond)
      C_ALWAYS:   jump = 1'b1;
      C_MORE:     jump = more;
      C_DIV_BUSY: jump = (div_cnt != KW'(1));
      default:    jump = 1'b0;
    endcase
    if (hold) begin
      step_next = step;
    end else if (jump) begin
      step_next = cw.target;
    end else begin
      step_next = step + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= STEP_WAIT;
    end else begin
      step <= step_next;
    end
  end

  // ring memory: one write on accept, one registered read per cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      ring[write_slot] <= {points.point_y, points.point_x};
    end
    rd_data <= ring[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot   <= '0;
      filled_count <= '0;
      idx          <= '0;
      bad_ok       <= 1'b0;
      estimates.valid <= 1'b0;
    end else begin
      if (cw.op == OP_EMIT && !hold) begin
        estimates.valid <= 1'b1;
      end else if (estimates.ready) begin
        estimates.valid <= 1'b0;
      end
      case (cw.op)
        OP_ACCEPT: begin
          if (accept) begin
            write_slot   <= (write_slot == IW'(WINDOW - 1)) ? '0 : write_slot + 1'b1;
            filled_count <= filled_next;
            idx          <= '0;
            bad_ok       <= 1'b0;
          end
        end
        OP_SUM, OP_COMPARE: begin
          idx <= more ? idx + 1'b1 : '0;
          if (cw.op == OP_COMPARE && dist_sq > best) begin
            bad_ok <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // payload and arithmetic registers
  always_ff @(posedge clk) begin
    case (cw.op)
      OP_ACCEPT: begin
        sx   <= '0;
        sy   <= '0;
        best <= '0;
      end
      OP_SUM: begin
        sx <= sx + {{(SW-COORD_W){px[COORD_W-1]}}, px};
        sy <= sy + {{(SW-COORD_W){py[COORD_W-1]}}, py};
      end
      OP_DIFF: begin
        dx <= nx - {{(DW-SW){sx[SW-1]}}, sx};
        dy <= ny - {{(DW-SW){sy[SW-1]}}, sy};
      end
      OP_SQUARE: begin
        sqx <= dx * dx;
        sqy <= dy * dy;
      end
      OP_COMPARE: begin
        // strict compare keeps the lowest slot on a tie
        if (dist_sq > best) begin
          best <= dist_sq;
          bx   <= px;
          by   <= py;
        end
      end
      OP_DIV_LOAD: begin
        quo_x   <= mag_x;
        quo_y   <= mag_y;
        neg_x   <= num_x[NW-1];
        neg_y   <= num_y[NW-1];
        rem_x   <= '0;
        rem_y   <= '0;
        den     <= bad_ok ? filled_count - 1'b1 : filled_count;
        div_cnt <= KW'(NW);
      end
      OP_DIV_STEP: begin
        // restoring division, one quotient bit per cycle
        if (rsh_x >= {1'b0, den}) begin
          rem_x <= CW'(rsh_x - {1'b0, den});
          quo_x <= {quo_x[NW-2:0], 1'b1};
        end else begin
          rem_x <= rsh_x[CW-1:0];
          quo_x <= {quo_x[NW-2:0], 1'b0};
        end
        if (rsh_y >= {1'b0, den}) begin
          rem_y <= CW'(rsh_y - {1'b0, den});
          quo_y <= {quo_y[NW-2:0], 1'b1};
        end else begin
          rem_y <= rsh_y[CW-1:0];
          quo_y <= {quo_y[NW-2:0], 1'b0};
        end
        div_cnt <= div_cnt - 1'b1;
      end
      OP_EMIT: begin
        if (!hold) begin
          estimates.est_x       <= res_x[COORD_W-1:0];
          estimates.est_y       <= res_y[COORD_W-1:0];
          estimates.points_held <= HELD_W'(filled_count);
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// File: sim/testbench.sv
// self-checking testbench for the point window outlier mean block
module testbench import pwom_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WINDOW      = 8;
  localparam int ITEM_CYCLES = 72;
  localparam int CYCLE_LIMIT = 500000;

  typedef struct packed {
    coord_t x;
    coord_t y;
    held_t  held;
  } estimate_t;

  logic clk;
  logic rst;

  pwom_point_if points_ch ();
  pwom_est_if   est_ch ();

  point_window_outlier_mean #(
    .WINDOW(WINDOW)
  ) DUT (
    .clk       (clk),
    .rst       (rst),
    .points    (points_ch),
    .estimates (est_ch)
  );

  // window model
  coord_t      ring_x [WINDOW];
  coord_t      ring_y [WINDOW];
  int unsigned next_slot;
  int unsigned held_count;

  estimate_t pending_estimates [$];
  int        errors;
  int        send_idle_pct;
  int        recv_idle_pct;
  int        recv_hold_cycles;
  int        cycle_count;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // store the point, then mean of the window without its farthest point, if one is found
  function automatic estimate_t track_window_estimate(coord_t x, coord_t y);
    estimate_t est;
    longint    sx, sy, n, best, dx, dy, d, rx, ry;
    int        drop;
    sx   = 0;
    sy   = 0;
    best = 0;
    drop = -1;
    ring_x[next_slot] = x;
    ring_y[next_slot] = y;
    next_slot = (next_slot + 1) % WINDOW;
    if (held_count < WINDOW) held_count++;
    n = held_count;
    for (int i = 0; i < held_count; i++) begin
      sx += ring_x[i];
      sy += ring_y[i];
    end
    if (held_count == 1) begin
      rx = ring_x[0];
      ry = ring_y[0];
    end else begin
      for (int i = 0; i < held_count; i++) begin
        dx = n * ring_x[i] - sx;
        dy = n * ring_y[i] - sy;
        d  = dx * dx + dy * dy;
        // strict compare keeps the lowest slot on a tie
        if (d > best) begin
          best = d;
          drop = i;
        end
      end
      if (drop < 0) begin
        rx = sx / n;
        ry = sy / n;
      end else begin
        rx = (sx - ring_x[drop]) / (n - 1);
        ry = (sy - ring_y[drop]) / (n - 1);
      end
    end
    est.x    = rx[COORD_W-1:0];
    est.y    = ry[COORD_W-1:0];
    est.held = held_t'(held_count);
    return est;
  endfunction

  task automatic send_point(input coord_t x, input coord_t y);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      points_ch.valid <= 1'b0;
      @(negedge clk);
    end
    points_ch.valid   <= 1'b1;
    points_ch.point_x <= x;
    points_ch.point_y <= y;
    @(posedge clk);
    while (!points_ch.ready) @(posedge clk);
    pending_estimates.push_back(track_window_estimate(x, y));
  endtask

  task automatic stop_sending();
    @(negedge clk);
    points_ch.valid <= 1'b0;
  endtask

  // drop the last request before waiting so it is not taken twice
  task automatic wait_drained();
    stop_sending();
    while (pending_estimates.size() != 0) @(posedge clk);
  endtask

  // receiver: random stalls, or a counted hold-off
  initial begin
    est_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (recv_hold_cycles > 0) begin
        est_ch.ready <= 1'b0;
        recv_hold_cycles--;
      end else begin
        est_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin
    estimate_t want;
    forever begin
      @(posedge clk);
      if (!rst && est_ch.valid && est_ch.ready) begin
        if (pending_estimates.size() == 0) begin
          $display("%0t: estimate with none pending: x=%0d y=%0d held=%0d", $time,
                   est_ch.est_x, est_ch.est_y, est_ch.points_held);
          errors++;
        end else begin
          want = pending_estimates.pop_front();
          if (est_ch.est_x !== want.x || est_ch.est_y !== want.y ||
              est_ch.points_held !== want.held) begin
            $display("%0t: mismatch: expected x=%0d y=%0d held=%0d, got x=%0d y=%0d held=%0d",
                     $time, want.x, want.y, want.held,
                     est_ch.est_x, est_ch.est_y, est_ch.points_held);
            errors++;
          end
        end
      end
    end
  end

  // first request after reset: one point held
  task automatic test_single_point();
    send_point(16'sd100, -16'sd200);
  endtask

  // two points are always equidistant from their mean
  task automatic test_distance_tie();
    send_point(16'sd300, 16'sd400);
  endtask

  // fill the window with one point: the last request finds no outlier, plain mean
  task automatic test_all_at_mean();
    for (int i = 0; i < WINDOW; i++) send_point(-16'sd32768, 16'sd32767);
  endtask

  task automatic test_field_extremes();
    send_point(16'sd32767, -16'sd32768);
    send_point(16'sd32767, 16'sd32767);
    send_point(-16'sd32768, -16'sd32768);
    send_point(16'sd0, 16'sd0);
    send_point(-16'sd1, -16'sd1);
    send_point(16'sd32767, 16'sd0);
    send_point(16'sd0, -16'sd32768);
    send_point(-16'sd1, 16'sd1);
  endtask

  // clusters with a few far points, exact repeats and full-range noise
  task automatic test_random_points(input int count);
    int     cx, cy, left, pick;
    coord_t x, y;
    left = 0;
    for (int i = 0; i < count; i++) begin
      if (left == 0) begin
        cx   = $urandom_range(64000) - 32000;
        cy   = $urandom_range(64000) - 32000;
        left = $urandom_range(16, 8);
      end
      left--;
      pick = $urandom_range(99);
      if (pick < 70) begin
        x = coord_t'(cx + $urandom_range(63) - 32);
        y = coord_t'(cy + $urandom_range(63) - 32);
      end else if (pick < 82) begin
        x = coord_t'(cx);
        y = coord_t'(cy);
      end else begin
        x = coord_t'($urandom());
        y = coord_t'($urandom());
      end
      send_point(x, y);
    end
  endtask

  // long receiver hold-off so the output register fills and input stalls
  task automatic test_output_backpressure();
    send_idle_pct    = 0;
    recv_hold_cycles = 800;
    test_random_points(10);
  endtask

  task automatic test_drain_pause();
    wait_drained();
    test_random_points(6);
  endtask

  initial begin
    errors            = 0;
    next_slot         = 0;
    held_count        = 0;
    send_idle_pct     = 0;
    recv_idle_pct     = 0;
    recv_hold_cycles  = 0;
    rst               = 1'b1;
    points_ch.valid   = 1'b0;
    points_ch.point_x = '0;
    points_ch.point_y = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_single_point();
    test_distance_tie();
    test_all_at_mean();
    test_field_extremes();

    send_idle_pct = 33;
    recv_idle_pct = 62;
    test_random_points(140);
    send_idle_pct = 62;
    recv_idle_pct = 33;
    test_random_points(140);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_points(140);

    test_output_backpressure();
    send_idle_pct = 20;
    recv_idle_pct = 20;
    test_drain_pause();
    stop_sending();

    wait_drained();
    repeat (2 * ITEM_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
design/pwom_pkg.sv
design/pwom_point_if.sv
design/pwom_est_if.sv
design/point_window_outlier_mean.sv
sim/testbench.sv
